@@ hdl/olad_pkg.sv @@
// shared types and constants for the ordered list core
`timescale 1ns / 1ps
`default_nettype none
package olad_pkg;

	// default list capacity
	localparam int DEPTH_DEF = 16;

	// command codes
	typedef enum logic [1:0] {
		OP_APPEND   = 2'd0,
		OP_REMOVE   = 2'd1,
		OP_DUMP_FWD = 2'd2,
		OP_DUMP_BWD = 2'd3
	} op_t;

	// response status codes
	typedef enum logic [2:0] {
		RS_DONE      = 3'd0,
		RS_NOT_FOUND = 3'd1,
		RS_EMPTY     = 3'd2,
		RS_FULL      = 3'd3,
		RS_ENTRY     = 3'd4
	} status_t;

	// command beat
	typedef struct packed {
		op_t                op;
		logic signed [31:0] value;
	} cmd_t;

	// response beat
	typedef struct packed {
		status_t            status;
		logic signed [31:0] entry_value;
		logic               last;
	} rsp_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE,
		S_REMOVE,
		S_DUMP_FWD,
		S_DUMP_BWD
	} state_t;

	// action applied to the cell row on each clock edge
	typedef enum logic [2:0] {
		CELL_HOLD,
		CELL_LOAD,
		CELL_FWD,
		CELL_BWD,
		CELL_SHIFT
	} cell_op_t;

	typedef struct packed {
		cell_op_t           op;
		logic signed [31:0] value;
	} cell_ctrl_t;

endpackage
`default_nettype wire

@@ hdl/olad_cell.sv @@
// one storage cell of the list row
`timescale 1ns / 1ps
`default_nettype none
module olad_cell import olad_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF,
	parameter int IDX   = 0
) (
	input  wire logic                         clk,
	input  wire cell_ctrl_t                   ctrl,
	input  wire logic [$clog2(DEPTH)-1:0]     sel,
	input  wire logic signed [31:0]           key,
	input  wire logic signed [31:0]           up,
	input  wire logic signed [31:0]           down,
	output logic signed [31:0]                data,
	output logic                              hit
);

	localparam int IW = $clog2(DEPTH);

	logic signed [31:0] data_q;
	logic               mine;

	// this cell is the one addressed by the controller
	assign mine = (sel == IW'(IDX));

	// compare against the search key when addressed
	assign hit  = mine && (data_q == key);
	assign data = data_q;

	// entry register, moves with its neighbours
	always_ff @(posedge clk) begin
		case (ctrl.op)
			CELL_HOLD:  data_q <= data_q;
			CELL_LOAD:  if (mine) data_q <= ctrl.value;
			CELL_FWD:   data_q <= up;
			CELL_BWD:   data_q <= down;
			CELL_SHIFT: if (mine) data_q <= up;
			default:    data_q <= data_q;
		endcase
	end

endmodule
`default_nettype wire

@@ hdl/olad_ctrl.sv @@
// sequencer for the list row: count, step index and response register
`timescale 1ns / 1ps
`default_nettype none
module olad_ctrl import olad_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       cmd_valid,
	output logic                            cmd_stall,
	input  wire cmd_t                       cmd,
	output logic                            rsp_valid,
	input  wire logic                       rsp_stall,
	output rsp_t                            rsp,
	output cell_ctrl_t                      cell_ctrl,
	output logic [$clog2(DEPTH)-1:0]        cell_sel,
	output logic signed [31:0]              cell_key,
	input  wire logic signed [31:0]         head,
	input  wire logic signed [31:0]         tail,
	input  wire logic [DEPTH-1:0]           hit
);

	localparam int IW = $clog2(DEPTH);
	localparam int CW = $clog2(DEPTH + 1);

	state_t             state_q, state_d;
	logic [IW-1:0]      k_q, k_d;
	logic [CW-1:0]      count_q, count_d;
	logic               found_q, found_d;
	logic signed [31:0] key_q, key_d;
	rsp_t               rsp_q, rsp_d;
	logic               rsp_valid_q;
	logic               emit;
	logic               slot_free;
	logic [CW-1:0]      k_ext;
	logic               full, empty;
	logic               final_step, found_now, emitting;

	assign slot_free = !rsp_valid_q || !rsp_stall;
	assign k_ext     = CW'(k_q);
	assign full      = (count_q == CW'(DEPTH));
	assign empty     = (count_q == '0);
	assign found_now = found_q || (|hit);

	// address: first free slot when idle, step index otherwise
	assign cell_sel = (state_q == S_IDLE) ? count_q[IW-1:0] : k_q;
	assign cell_key = key_q;

	// next state and row control
	always_comb begin
		state_d    = state_q;
		k_d        = k_q;
		count_d    = count_q;
		found_d    = found_q;
		key_d      = key_q;
		emit       = 1'b0;
		rsp_d      = '{status: RS_DONE, entry_value: '0, last: 1'b1};
		cell_ctrl  = '{op: CELL_HOLD, value: cmd.value};
		cmd_stall  = 1'b1;
		final_step = 1'b0;
		emitting   = 1'b0;
		case (state_q)
			S_IDLE: begin
				cmd_stall = !slot_free;
				if (cmd_valid && slot_free) begin
					case (cmd.op)
						OP_APPEND: begin
							emit = 1'b1;
							if (full) begin
								rsp_d.status = RS_FULL;
							end else begin
								cell_ctrl.op = CELL_LOAD;
								count_d      = count_q + 1'b1;
							end
						end
						OP_REMOVE: begin
							if (empty) begin
								emit         = 1'b1;
								rsp_d.status = RS_EMPTY;
							end else begin
								key_d   = cmd.value;
								found_d = 1'b0;
								k_d     = '0;
								state_d = S_REMOVE;
							end
						end
						default: begin
							if (empty) begin
								emit         = 1'b1;
								rsp_d.status = RS_EMPTY;
							end else begin
								k_d     = '0;
								state_d = (cmd.op == OP_DUMP_FWD) ? S_DUMP_FWD : S_DUMP_BWD;
							end
						end
					endcase
				end
			end
			// search token walks the row; after a match each cell takes its upper neighbour
			S_REMOVE: begin
				final_step = (k_ext == count_q - 1'b1);
				if (!final_step || slot_free) begin
					if (found_now) cell_ctrl.op = CELL_SHIFT;
					found_d = found_now;
					k_d     = k_q + 1'b1;
					if (final_step) begin
						emit    = 1'b1;
						state_d = S_IDLE;
						if (found_now) begin
							count_d           = count_q - 1'b1;
							rsp_d.entry_value = key_q;
						end else begin
							rsp_d.status = RS_NOT_FOUND;
						end
					end
				end
			end
			// full rotation toward the head, emit from cell zero
			S_DUMP_FWD: begin
				emitting = (k_ext < count_q);
				if (!emitting || slot_free) begin
					cell_ctrl.op = CELL_FWD;
					k_d          = k_q + 1'b1;
					if (emitting) begin
						emit              = 1'b1;
						rsp_d.status      = RS_ENTRY;
						rsp_d.entry_value = head;
						rsp_d.last        = (k_ext == count_q - 1'b1);
					end
					if (k_q == IW'(DEPTH - 1)) state_d = S_IDLE;
				end
			end
			// full rotation toward the top, emit from the last cell
			S_DUMP_BWD: begin
				emitting = (k_ext >= (CW'(DEPTH) - count_q));
				if (!emitting || slot_free) begin
					cell_ctrl.op = CELL_BWD;
					k_d          = k_q + 1'b1;
					if (emitting) begin
						emit              = 1'b1;
						rsp_d.status      = RS_ENTRY;
						rsp_d.entry_value = tail;
						rsp_d.last        = (k_q == IW'(DEPTH - 1));
					end
					if (k_q == IW'(DEPTH - 1)) state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			k_q         <= '0;
			count_q     <= '0;
			found_q     <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			k_q     <= k_d;
			count_q <= count_d;
			found_q <= found_d;
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		key_q <= key_d;
		if (emit) rsp_q <= rsp_d;
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule
`default_nettype wire

@@ hdl/ordered_list_append_delete_core.sv @@
// Ordered list core: row of DEPTH entry cells driven by one sequencer.
// Append, and any command on an empty list: beat registered as the command is accepted.
// Remove: a search token walks live cells one per cycle, then one beat once the slot is free.
// Dumps: the row rotates one place per cycle through one full turn, one beat per live entry;
//   a stalled response beat holds the rotation. One command in flight at a time.
// Reset clears the count, the sequencer state and the response valid; entries are not cleared.
`timescale 1ns / 1ps
`default_nettype none
module ordered_list_append_delete_core import olad_pkg::*; #(
	parameter int DEPTH = DEPTH_DEF
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  cmd_valid,
	output logic       cmd_stall,
	input  wire cmd_t  cmd,
	output logic       rsp_valid,
	input  wire logic  rsp_stall,
	output rsp_t       rsp
);

	localparam int IW = $clog2(DEPTH);

	cell_ctrl_t         cell_ctrl;
	logic [IW-1:0]      cell_sel;
	logic signed [31:0] cell_key;
	logic signed [31:0] cell_data [DEPTH];
	logic [DEPTH-1:0]   hit;

	// sequencer
	olad_ctrl #(
		.DEPTH(DEPTH)
	) u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd_valid (cmd_valid),
		.cmd_stall (cmd_stall),
		.cmd       (cmd),
		.rsp_valid (rsp_valid),
		.rsp_stall (rsp_stall),
		.rsp       (rsp),
		.cell_ctrl (cell_ctrl),
		.cell_sel  (cell_sel),
		.cell_key  (cell_key),
		.head      (cell_data[0]),
		.tail      (cell_data[DEPTH-1]),
		.hit       (hit)
	);

	// row of cells, closed into a ring for rotation
	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		olad_cell #(
			.DEPTH(DEPTH),
			.IDX  (i)
		) u_cell (
			.clk  (clk),
			.ctrl (cell_ctrl),
			.sel  (cell_sel),
			.key  (cell_key),
			.up   (cell_data[(i + 1) % DEPTH]),
			.down (cell_data[(i + DEPTH - 1) % DEPTH]),
			.data (cell_data[i]),
			.hit  (hit[i])
		);
	end

endmodule
`default_nettype wire
